// ----- design/depth_to_point_transform_defines.svh -----
// ----------------------------------------------------------------------------
// depth_to_point_transform_defines
// Assertion macros for the checker file of the depth to point block.
// ----------------------------------------------------------------------------
`ifndef DEPTH_TO_POINT_TRANSFORM_DEFINES_SVH
`define DEPTH_TO_POINT_TRANSFORM_DEFINES_SVH

// Same-cycle implication, disabled while reset is active.
`define DTP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: label");

// Next-cycle implication, disabled while reset is active.
`define DTP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: label");

`endif

// ----- design/dtp_pkg.sv -----
// ----------------------------------------------------------------------------
// dtp_pkg
// Sizes, codes and types shared by the depth to point transform files.
// ----------------------------------------------------------------------------
`default_nettype none

package dtp_pkg;

  // Sensor geometry and ray format.
  localparam int MAX_COLS      = 512;
  localparam int MAX_ROWS      = 256;
  localparam int RAY_FRAC_BITS = 15;

  // Field widths of the request and the result.
  localparam int COL_W   = 9;
  localparam int ROW_W   = 8;
  localparam int DEPTH_W = 16;
  localparam int RAY_W   = 16;
  localparam int POINT_W = 17;

  // Product of the zero-extended depth and a signed ray component.
  localparam int PROD_W = DEPTH_W + 1 + RAY_W;

  // Ray table addressing.
  localparam int TABLE_DEPTH = MAX_COLS * MAX_ROWS;
  localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  // Configuration port.
  localparam int AW_W       = 10;
  localparam int AH_W       = 9;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;
  localparam logic [AW_W-1:0] ACTIVE_WIDTH_RST  = AW_W'(320);
  localparam logic [AH_W-1:0] ACTIVE_HEIGHT_RST = AH_W'(240);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ACTIVE_WIDTH  = 2'd0,
    REG_ACTIVE_HEIGHT = 2'd1
  } cfg_reg_e;

  typedef enum logic {
    OP_LOAD      = 1'b0,
    OP_TRANSFORM = 1'b1
  } op_e;

  // One table entry: the three ray components.
  typedef struct packed {
    logic signed [RAY_W-1:0] x;
    logic signed [RAY_W-1:0] y;
    logic signed [RAY_W-1:0] z;
  } ray_t;

  // Access to the ray table for one cycle.
  typedef struct packed {
    logic              we;
    logic              re;
    logic [ADDR_W-1:0] addr;
    ray_t              wdata;
  } mem_req_t;

endpackage

`default_nettype wire

// ----- design/dtp_req_if.sv -----
// ----------------------------------------------------------------------------
// dtp_req_if
// Request channel: ray loads and depth pixels with a valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface dtp_req_if
  import dtp_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic                      operation;
  logic [COL_W-1:0]          pixel_col;
  logic [ROW_W-1:0]          pixel_row;
  logic [DEPTH_W-1:0]        depth_mm;
  logic signed [RAY_W-1:0]   ray_x_in;
  logic signed [RAY_W-1:0]   ray_y_in;
  logic signed [RAY_W-1:0]   ray_z_in;

  modport source (
    output valid, operation, pixel_col, pixel_row, depth_mm,
           ray_x_in, ray_y_in, ray_z_in,
    input  ready
  );

  modport sink (
    input  valid, operation, pixel_col, pixel_row, depth_mm,
           ray_x_in, ray_y_in, ray_z_in,
    output ready
  );
endinterface

`default_nettype wire

// ----- design/dtp_pnt_if.sv -----
// ----------------------------------------------------------------------------
// dtp_pnt_if
// Result channel: one 3D point per depth pixel with a valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface dtp_pnt_if
  import dtp_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic signed [POINT_W-1:0] point_x;
  logic signed [POINT_W-1:0] point_y;
  logic signed [POINT_W-1:0] point_z;
  logic                      range_error;

  modport source (
    output valid, point_x, point_y, point_z, range_error,
    input  ready
  );

  modport sink (
    input  valid, point_x, point_y, point_z, range_error,
    output ready
  );
endinterface

`default_nettype wire

// ----- design/depth_to_point_transform.sv -----
// ----------------------------------------------------------------------------
// depth_to_point_transform
// Turns depth pixels into 3D points using a per-pixel table of unit rays.
// ----------------------------------------------------------------------------
// The block takes one request per cycle, loads and depth pixels alike, unless a
// stalled result backs up the pipeline. A depth pixel passes in order through
// the registered read of the ray table, the three depth-by-ray multipliers
// and the output register, which then offers its point. A ray
// load writes the table in the cycle it is taken and gives no result; a pixel
// may be transformed in the very next cycle after its ray is loaded. The ray
// table holds no defined content after reset and needs no clearing pass, so
// the first request is taken right after reset; a pixel must have its ray
// loaded before it is transformed. Pixels outside the active size give a
// zero point with range_error set, and loads outside it are dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module depth_to_point_transform
  import dtp_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  dtp_req_if.sink                    req_i,
  dtp_pnt_if.source                  pnt_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam logic signed [PROD_W-1:0] SAT_HI = PROD_W'((1 << (POINT_W - 1)) - 1);
  localparam logic signed [PROD_W-1:0] SAT_LO = ~SAT_HI;

  // Floor shift of a product to millimetres, clamped to the point range.
  function automatic logic signed [POINT_W-1:0] scale_sat(
    input logic signed [PROD_W-1:0] p
  );
    logic signed [PROD_W-1:0] s;
    s = p >>> RAY_FRAC_BITS;
    if (s > SAT_HI) begin
      s = SAT_HI;
    end else if (s < SAT_LO) begin
      s = SAT_LO;
    end
    return s[POINT_W-1:0];
  endfunction

  logic [AW_W-1:0] width_q;
  logic [AH_W-1:0] height_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= ACTIVE_WIDTH_RST;
      height_q <= ACTIVE_HEIGHT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_ACTIVE_WIDTH:  width_q  <= cfg_data_i[AW_W-1:0];
        REG_ACTIVE_HEIGHT: height_q <= cfg_data_i[AH_W-1:0];
        default: ;
      endcase
    end
  end

  // Stage enables: a stage moves on when it is empty or its successor moves.
  logic v1_q, v2_q, v3_q;
  logic en1, en2, en3;
  logic accept;

  assign en3         = !v3_q || pnt_o.ready;
  assign en2         = !v2_q || en3;
  assign en1         = !v1_q || en2;
  assign req_i.ready = en1;
  assign accept      = req_i.valid && en1;

  // Range check and table address of the incoming request.
  logic              in_range;
  logic              is_xform;
  logic [ADDR_W-1:0] addr;
  mem_req_t          mem_req;
  ray_t              ray_rd;

  assign in_range = ({1'b0, req_i.pixel_col} < width_q)
                 && ({1'b0, req_i.pixel_row} < height_q)
                 && (32'(req_i.pixel_col) < MAX_COLS)
                 && (32'(req_i.pixel_row) < MAX_ROWS);
  assign is_xform = (op_e'(req_i.operation) == OP_TRANSFORM);
  assign addr     = ADDR_W'(32'(req_i.pixel_row) * MAX_COLS + 32'(req_i.pixel_col));

  always_comb begin
    mem_req.we      = accept && !is_xform && in_range;
    mem_req.re      = accept && is_xform && in_range;
    mem_req.addr    = addr;
    mem_req.wdata.x = req_i.ray_x_in;
    mem_req.wdata.y = req_i.ray_y_in;
    mem_req.wdata.z = req_i.ray_z_in;
  end

  dtp_ray_store u_store (
    .clk_i     (clk_i),
    .mem_req_i (mem_req),
    .rdata_o   (ray_rd)
  );

  // Stage valid bits; loads leave no item behind.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) begin
        v1_q <= accept && is_xform;
      end
      if (en2) begin
        v2_q <= v1_q;
      end
      if (en3) begin
        v3_q <= v2_q;
      end
    end
  end

  // Stage 1: pixel data beside the table read.
  logic [DEPTH_W-1:0] depth1_q;
  logic               err1_q;

  always_ff @(posedge clk_i) begin
    if (en1) begin
      depth1_q <= req_i.depth_mm;
      err1_q   <= !in_range;
    end
  end

  // Stage 2: depth times each ray component; out-of-range pixels give zero.
  logic signed [DEPTH_W:0]   depth_s;
  logic signed [PROD_W-1:0]  prod_x_q, prod_y_q, prod_z_q;
  logic                      err2_q;

  assign depth_s = $signed({1'b0, depth1_q});

  always_ff @(posedge clk_i) begin
    if (en2) begin
      err2_q <= err1_q;
      if (err1_q) begin
        prod_x_q <= '0;
        prod_y_q <= '0;
        prod_z_q <= '0;
      end else begin
        prod_x_q <= depth_s * ray_rd.x;
        prod_y_q <= depth_s * ray_rd.y;
        prod_z_q <= depth_s * ray_rd.z;
      end
    end
  end

  // Stage 3: output register with shift and clamp.
  logic signed [POINT_W-1:0] pt_x_q, pt_y_q, pt_z_q;
  logic                      err3_q;

  always_ff @(posedge clk_i) begin
    if (en3) begin
      pt_x_q <= scale_sat(prod_x_q);
      pt_y_q <= scale_sat(prod_y_q);
      pt_z_q <= scale_sat(prod_z_q);
      err3_q <= err2_q;
    end
  end

  assign pnt_o.valid       = v3_q;
  assign pnt_o.point_x     = pt_x_q;
  assign pnt_o.point_y     = pt_y_q;
  assign pnt_o.point_z     = pt_z_q;
  assign pnt_o.range_error = err3_q;

endmodule

`default_nettype wire

// ----- design/dtp_ray_store.sv -----
// ----------------------------------------------------------------------------
// dtp_ray_store
// Per-pixel ray table: one synchronous write or registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module dtp_ray_store
  import dtp_pkg::*;
(
  input  wire logic     clk_i,
  input  wire mem_req_t mem_req_i,
  output ray_t          rdata_o
);

  ray_t mem_q [TABLE_DEPTH];
  ray_t rdata_q;

  // Table write for a ray load.
  always_ff @(posedge clk_i) begin
    if (mem_req_i.we) begin
      mem_q[mem_req_i.addr] <= mem_req_i.wdata;
    end
  end

  // Registered read; the data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (mem_req_i.re) begin
      rdata_q <= mem_q[mem_req_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- design/dtp_checker.sv -----
// ----------------------------------------------------------------------------
// dtp_checker
// Port-level checks of the depth to point transform, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "depth_to_point_transform_defines.svh"

module dtp_checker
  import dtp_pkg::*;
(
  input wire logic                      clk_i,
  input wire logic                      rst_ni,
  input wire logic                      req_valid_i,
  input wire logic                      req_ready_i,
  input wire logic                      pnt_valid_i,
  input wire logic                      pnt_ready_i,
  input wire logic signed [POINT_W-1:0] point_x_i,
  input wire logic signed [POINT_W-1:0] point_y_i,
  input wire logic signed [POINT_W-1:0] point_z_i,
  input wire logic                      range_error_i
);

  logic req_acc;
  logic pnt_stall;

  assign req_acc   = req_valid_i && req_ready_i;
  assign pnt_stall = pnt_valid_i && !pnt_ready_i;

  // A stalled point stays offered and unchanged.
  `DTP_ASSERT_NEXT(a_pnt_hold, clk_i, rst_ni, pnt_stall, pnt_valid_i && $stable(point_x_i) && $stable(point_y_i) && $stable(point_z_i) && $stable(range_error_i))

  // An out-of-range pixel always gives the zero point.
  `DTP_ASSERT_IMPL(a_err_zero, clk_i, rst_ni, pnt_valid_i && range_error_i, point_x_i == '0 && point_y_i == '0 && point_z_i == '0)

  // With no point waiting, the block always takes a request.
  `DTP_ASSERT_IMPL(a_ready_free, clk_i, rst_ni, !pnt_valid_i, req_ready_i)

  // Idle cycles with the result side ready drain the pipeline and leave no point behind.
  `DTP_ASSERT_IMPL(a_drain, clk_i, rst_ni, !$past(req_acc, 1) && !$past(req_acc, 2) && !$past(req_acc, 3) && $past(pnt_ready_i, 1) && $past(pnt_ready_i, 2) && $past(pnt_ready_i, 3), !pnt_valid_i)

endmodule

bind depth_to_point_transform dtp_checker u_dtp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .req_valid_i   (req_i.valid),
  .req_ready_i   (req_i.ready),
  .pnt_valid_i   (pnt_o.valid),
  .pnt_ready_i   (pnt_o.ready),
  .point_x_i     (pnt_o.point_x),
  .point_y_i     (pnt_o.point_y),
  .point_z_i     (pnt_o.point_z),
  .range_error_i (pnt_o.range_error)
);

`default_nettype wire

// ----- verif/tb_depth_to_point_transform.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_depth_to_point_transform
// Self-checking bench for the depth to point block. Ray loads and depth pixel
// requests are streamed through the request channel under several active
// sizes and idling patterns. A scoreboard keeps its own ray table and sizes,
// predicts each point and compares it field by field with the result channel.
// ----------------------------------------------------------------------------

module tb_depth_to_point_transform;
  import dtp_pkg::*;

  localparam int CLK_HALF       = 5;
  localparam int RESET_CYCLES   = 5;
  localparam int SETTLE_CYCLES  = 8;
  localparam int TIMEOUT_NS     = 3_000_000;
  localparam int N_PHASES       = 7;
  localparam int ITEMS_PER_PHASE = 86;
  localparam int SEND_IDLE_PCT  = 63;
  localparam int RECV_STALL_PCT = 63;
  localparam int BOTH_IDLE_PCT  = 16;

  // Index beyond the two registers; writes to it must be ignored.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  // Active sizes per phase; the first height carries a bit beyond the register.
  localparam int unsigned PHASE_WIDTH [N_PHASES]  = '{512, 1, 1023, 0, 17, 320, 512};
  localparam int unsigned PHASE_HEIGHT [N_PHASES] = '{768, 1, 511, 256, 5, 240, 200};

  typedef struct packed {
    logic signed [POINT_W-1:0] x;
    logic signed [POINT_W-1:0] y;
    logic signed [POINT_W-1:0] z;
    logic                      range_error;
  } point_t;

  // Predicts points from its own copy of the ray table and active size.
  class point_scoreboard;
    int unsigned active_width;
    int unsigned active_height;
    ray_t        ray_table [int unsigned];
    point_t      point_q [$];
    int unsigned fail_count;

    function new();
      active_width  = ACTIVE_WIDTH_RST;
      active_height = ACTIVE_HEIGHT_RST;
      fail_count    = 0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == REG_ACTIVE_WIDTH) begin
        active_width = data[AW_W-1:0];
      end else if (idx == REG_ACTIVE_HEIGHT) begin
        active_height = data[AH_W-1:0];
      end
    endfunction

    function bit in_range(int unsigned col, int unsigned row);
      return col < active_width && row < active_height && col < MAX_COLS && row < MAX_ROWS;
    endfunction

    static function int unsigned pixel_addr(int unsigned col, int unsigned row);
      return row * MAX_COLS + col;
    endfunction

    // Depth times ray, floored by the fraction bits and clamped to the point width.
    static function logic signed [POINT_W-1:0] scale_ray(logic [DEPTH_W-1:0] depth,
                                                         logic signed [RAY_W-1:0] ray);
      longint prod;
      longint q;
      prod = longint'(depth) * longint'(ray);
      q = prod >>> RAY_FRAC_BITS;
      if (q < -(longint'(1) <<< (POINT_W - 1))) q = -(longint'(1) <<< (POINT_W - 1));
      if (q > (longint'(1) <<< (POINT_W - 1)) - 1) q = (longint'(1) <<< (POINT_W - 1)) - 1;
      return q[POINT_W-1:0];
    endfunction

    function int unsigned pending();
      return point_q.size();
    endfunction

    function void note_request(op_e op, int unsigned col, int unsigned row,
                               logic [DEPTH_W-1:0] depth, logic signed [RAY_W-1:0] rx,
                               logic signed [RAY_W-1:0] ry, logic signed [RAY_W-1:0] rz);
      ray_t   ray;
      point_t pt;
      if (op == OP_LOAD) begin
        if (in_range(col, row)) begin
          ray.x = rx;
          ray.y = ry;
          ray.z = rz;
          ray_table[pixel_addr(col, row)] = ray;
        end
        return;
      end
      if (!in_range(col, row)) begin
        pt = '0;
        pt.range_error = 1'b1;
      end else begin
        ray = ray_table[pixel_addr(col, row)];
        pt.x = scale_ray(depth, ray.x);
        pt.y = scale_ray(depth, ray.y);
        pt.z = scale_ray(depth, ray.z);
        pt.range_error = 1'b0;
      end
      point_q.push_back(pt);
    endfunction

    function void check_point(point_t got);
      point_t exp_pt;
      if (point_q.size() == 0) begin
        $error("unexpected point: x %0d y %0d z %0d range_error %0b",
               got.x, got.y, got.z, got.range_error);
        fail_count++;
        return;
      end
      exp_pt = point_q.pop_front();
      if (got.x !== exp_pt.x) begin
        $error("point_x: expected %0d, got %0d", exp_pt.x, got.x);
        fail_count++;
      end
      if (got.y !== exp_pt.y) begin
        $error("point_y: expected %0d, got %0d", exp_pt.y, got.y);
        fail_count++;
      end
      if (got.z !== exp_pt.z) begin
        $error("point_z: expected %0d, got %0d", exp_pt.z, got.z);
        fail_count++;
      end
      if (got.range_error !== exp_pt.range_error) begin
        $error("range_error: expected %0b, got %0b", exp_pt.range_error, got.range_error);
        fail_count++;
      end
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  dtp_req_if req_ch ();
  dtp_pnt_if pnt_ch ();

  point_scoreboard sb;
  int unsigned     send_idle_pct  = 0;
  int unsigned     recv_stall_pct = 0;

  // Pixels whose ray has been loaded, so transforms never read an empty entry.
  bit          loaded_map [int unsigned];
  int unsigned loaded_list [$];

  depth_to_point_transform u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_ch),
    .pnt_o      (pnt_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always #CLK_HALF clk_i = ~clk_i;

  // Result side stalls at the rate of the current phase.
  always @(posedge clk_i) begin
    pnt_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Record accepted requests and check accepted points.
  always @(posedge clk_i) begin
    point_t got;
    if (rst_ni) begin
      if (req_ch.valid && req_ch.ready) begin
        sb.note_request(op_e'(req_ch.operation), req_ch.pixel_col, req_ch.pixel_row,
                        req_ch.depth_mm, req_ch.ray_x_in, req_ch.ray_y_in, req_ch.ray_z_in);
      end
      if (pnt_ch.valid && pnt_ch.ready) begin
        got.x = pnt_ch.point_x;
        got.y = pnt_ch.point_y;
        got.z = pnt_ch.point_z;
        got.range_error = pnt_ch.range_error;
        sb.check_point(got);
      end
    end
  end

  // Present one request, after random idle cycles, and wait until it is taken.
  task automatic send_request(op_e op, int unsigned col, int unsigned row,
                              logic [DEPTH_W-1:0] depth, logic signed [RAY_W-1:0] rx,
                              logic signed [RAY_W-1:0] ry, logic signed [RAY_W-1:0] rz);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_ch.valid     <= 1'b1;
    req_ch.operation <= op;
    req_ch.pixel_col <= col[COL_W-1:0];
    req_ch.pixel_row <= row[ROW_W-1:0];
    req_ch.depth_mm  <= depth;
    req_ch.ray_x_in  <= rx;
    req_ch.ray_y_in  <= ry;
    req_ch.ray_z_in  <= rz;
    do @(posedge clk_i); while (!req_ch.ready);
  endtask

  task automatic load_ray(int unsigned col, int unsigned row, logic signed [RAY_W-1:0] rx,
                          logic signed [RAY_W-1:0] ry, logic signed [RAY_W-1:0] rz);
    int unsigned a;
    a = point_scoreboard::pixel_addr(col, row);
    send_request(OP_LOAD, col, row, DEPTH_W'($urandom), rx, ry, rz);
    if (sb.in_range(col, row) && !loaded_map.exists(a)) begin
      loaded_map[a] = 1'b1;
      loaded_list.push_back(a);
    end
  endtask

  task automatic transform_pixel(int unsigned col, int unsigned row, logic [DEPTH_W-1:0] depth);
    send_request(OP_TRANSFORM, col, row, depth, RAY_W'($urandom), RAY_W'($urandom),
                 RAY_W'($urandom));
  endtask

  // Hold off requests until every point is out and the pipeline is empty.
  task automatic settle();
    req_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    sb.set_register(idx, data);
  endtask

  function automatic logic signed [RAY_W-1:0] rand_ray();
    case ($urandom_range(7))
      0: return {1'b1, {(RAY_W - 1){1'b0}}};
      1: return {1'b0, {(RAY_W - 1){1'b1}}};
      2: return '0;
      3: return '1;
      default: return RAY_W'($urandom);
    endcase
  endfunction

  function automatic logic [DEPTH_W-1:0] rand_depth();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      default: return DEPTH_W'($urandom);
    endcase
  endfunction

  function automatic bit pick_inside(output int unsigned col, output int unsigned row);
    int unsigned eff_w;
    int unsigned eff_h;
    eff_w = (sb.active_width < MAX_COLS) ? sb.active_width : MAX_COLS;
    eff_h = (sb.active_height < MAX_ROWS) ? sb.active_height : MAX_ROWS;
    col = 0;
    row = 0;
    if (eff_w == 0 || eff_h == 0) return 1'b0;
    col = $urandom_range(eff_w - 1);
    row = $urandom_range(eff_h - 1);
    return 1'b1;
  endfunction

  function automatic bit pick_outside(output int unsigned col, output int unsigned row);
    col = 0;
    row = 0;
    for (int i = 0; i < 16; i++) begin
      col = $urandom_range(MAX_COLS - 1);
      row = $urandom_range(MAX_ROWS - 1);
      if (!sb.in_range(col, row)) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic bit pick_loaded(output int unsigned col, output int unsigned row);
    int unsigned a;
    col = 0;
    row = 0;
    if (loaded_list.size() == 0) return 1'b0;
    for (int i = 0; i < 8; i++) begin
      a = loaded_list[$urandom_range(loaded_list.size() - 1)];
      col = a % MAX_COLS;
      row = a / MAX_COLS;
      if (sb.in_range(col, row)) return 1'b1;
    end
    return 1'b0;
  endfunction

  // Corners, extreme rays and depths, overwrites and out-of-range pixels at the reset size.
  task automatic run_directed();
    load_ray(0, 0, 16'sh7FFF, 16'sh8000, 16'sh0000);
    transform_pixel(0, 0, 16'hFFFF);
    transform_pixel(0, 0, 16'h0000);
    transform_pixel(0, 0, 16'h0001);
    load_ray(319, 239, 16'shFFFF, 16'sh0001, 16'sh8000);
    transform_pixel(319, 239, 16'hFFFF);
    transform_pixel(319, 239, 16'd12345);
    load_ray(300, 128, 16'sh4000, 16'shC000, 16'sh7FFF);
    transform_pixel(300, 128, 16'd40000);
    load_ray(300, 128, 16'sh5A5A, 16'shA5A5, 16'sh0F0F);
    transform_pixel(300, 128, 16'hFFFF);
    transform_pixel(320, 0, 16'd1000);
    transform_pixel(0, 240, 16'hFFFF);
    transform_pixel(511, 255, 16'hFFFF);
    load_ray(320, 10, 16'sh1234, 16'sh5678, 16'sh9ABC);
    load_ray(0, 240, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
    transform_pixel(0, 0, 16'h8000);
    transform_pixel(319, 239, 16'h7FFF);
  endtask

  // Mostly load-then-transform traffic on loaded pixels, with out-of-range noise.
  task automatic run_random(int unsigned target);
    int unsigned issued;
    int unsigned col;
    int unsigned row;
    int unsigned r;
    issued = 0;
    while (issued < target) begin
      r = $urandom_range(99);
      if (r < 10) begin
        if (pick_outside(col, row)) begin
          transform_pixel(col, row, rand_depth());
          issued++;
        end
      end else if (r < 15) begin
        if (pick_outside(col, row)) load_ray(col, row, rand_ray(), rand_ray(), rand_ray());
      end else if (r < 45) begin
        if (pick_inside(col, row)) begin
          load_ray(col, row, rand_ray(), rand_ray(), rand_ray());
          issued++;
        end
      end else if (pick_loaded(col, row)) begin
        transform_pixel(col, row, rand_depth());
        issued++;
      end else if (pick_inside(col, row)) begin
        load_ray(col, row, rand_ray(), rand_ray(), rand_ray());
        transform_pixel(col, row, rand_depth());
        issued += 2;
      end
      if ($urandom_range(199) == 0) settle();
    end
  endtask

  initial begin
    sb = new();
    rst_ni           <= 1'b0;
    cfg_we_i         <= 1'b0;
    cfg_idx_i        <= REG_ACTIVE_WIDTH;
    cfg_data_i       <= '0;
    req_ch.valid     <= 1'b0;
    req_ch.operation <= OP_LOAD;
    req_ch.pixel_col <= '0;
    req_ch.pixel_row <= '0;
    req_ch.depth_mm  <= '0;
    req_ch.ray_x_in  <= '0;
    req_ch.ray_y_in  <= '0;
    req_ch.ray_z_in  <= '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    run_directed();

    // Each phase sets a new active size and idling pattern on an idle block.
    for (int ph = 0; ph < N_PHASES; ph++) begin
      settle();
      case (ph % 4)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = SEND_IDLE_PCT;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = RECV_STALL_PCT;
        end
        default: begin
          send_idle_pct  = BOTH_IDLE_PCT;
          recv_stall_pct = BOTH_IDLE_PCT;
        end
      endcase
      write_register(REG_ACTIVE_WIDTH, CFG_DATA_W'(PHASE_WIDTH[ph]));
      write_register(REG_ACTIVE_HEIGHT, CFG_DATA_W'(PHASE_HEIGHT[ph]));
      if (ph == 2) write_register(REG_SPARE, CFG_DATA_W'(7));
      run_random(ITEMS_PER_PHASE);
    end

    settle();
    if (sb.fail_count == 0) begin
      $display("tb_depth_to_point_transform passed");
    end else begin
      $display("tb_depth_to_point_transform failed");
    end
    $finish;
  end

  // Hard stop in case the block hangs.
  initial begin
    #(TIMEOUT_NS);
    $display("tb_depth_to_point_transform failed");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+design
design/dtp_pkg.sv
design/dtp_req_if.sv
design/dtp_pnt_if.sv
design/dtp_ray_store.sv
design/depth_to_point_transform.sv
design/dtp_checker.sv
verif/tb_depth_to_point_transform.sv
